// File: rtl/pdm_pkg.sv
`timescale 1ns / 1ps

package pdm_pkg;

   localparam int DATA_W  = 32;
   localparam int WB_W    = 31;
   localparam int SUM_W   = 48;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 66;
   localparam int CSR_A_W = 2;

   localparam logic [CSR_A_W-1:0] CSR_GAIN_PROP  = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_GAIN_INTEG = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_GAIN_DERIV = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_WHEEL_BASE = 2'd3;

   localparam logic signed [PROD_W-1:0] SAT32_MAX = 66'sd2147483647;
   localparam logic signed [PROD_W-1:0] SAT32_MIN = -66'sd2147483648;
   localparam logic signed [SUM_W:0]    SAT48_MAX = 49'sd140737488355327;
   localparam logic signed [SUM_W:0]    SAT48_MIN = -49'sd140737488355328;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_ERR,
      STEP_MUL_P,
      STEP_MUL_IL,
      STEP_MUL_IH,
      STEP_MUL_D,
      STEP_SUM,
      STEP_MUL_W,
      STEP_WHEEL
   } step_type;

   typedef struct packed {
      logic     capture;
      step_type step;
   } cmd_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > SAT32_MAX) begin
         r = 32'sh7fffffff;
      end else if (x < SAT32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W:0] x);
      logic signed [SUM_W-1:0] r;
      if (x > SAT48_MAX) begin
         r = SAT48_MAX[SUM_W-1:0];
      end else if (x < SAT48_MIN) begin
         r = SAT48_MIN[SUM_W-1:0];
      end else begin
         r = x[SUM_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/pdm_ctrl.sv
`timescale 1ns / 1ps

module pdm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pdm_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERR,
      S_MUL_P,
      S_MUL_IL,
      S_MUL_IH,
      S_MUL_D,
      S_SUM,
      S_MUL_W,
      S_WHEEL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.step    = pdm_pkg::STEP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_ERR;
            end
         end
         S_ERR: begin
            cmd.step = pdm_pkg::STEP_ERR;
            state_in = S_MUL_P;
         end
         S_MUL_P: begin
            cmd.step = pdm_pkg::STEP_MUL_P;
            state_in = S_MUL_IL;
         end
         S_MUL_IL: begin
            cmd.step = pdm_pkg::STEP_MUL_IL;
            state_in = S_MUL_IH;
         end
         S_MUL_IH: begin
            cmd.step = pdm_pkg::STEP_MUL_IH;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            cmd.step = pdm_pkg::STEP_MUL_D;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.step = pdm_pkg::STEP_SUM;
            state_in = S_MUL_W;
         end
         S_MUL_W: begin
            cmd.step = pdm_pkg::STEP_MUL_W;
            state_in = S_WHEEL;
         end
         S_WHEEL: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.step = pdm_pkg::STEP_WHEEL;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = (cmd.step == pdm_pkg::STEP_WHEEL) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_ERR))
      else $error("accepted transfer did not start the sequence");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == pdm_pkg::STEP_WHEEL) |=> rsp_valid_ff)
      else $error("result load did not raise rsp_valid");

   a_wheel_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WHEEL && rsp_valid_ff && rsp_stall) |=> (state_ff == S_WHEEL))
      else $error("result overwritten while output stalled");

   a_rise_from_wheel: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_WHEEL))
      else $error("rsp_valid rose outside the final step");
`endif

endmodule

// File: rtl/pdm_dp.sv
`timescale 1ns / 1ps

module pdm_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pdm_pkg::cmd_type                       cmd,
   input  logic                                   csr_valid,
   input  logic        [pdm_pkg::CSR_A_W-1:0]     csr_index,
   input  logic        [pdm_pkg::DATA_W-1:0]      csr_wdata,
   input  logic signed [pdm_pkg::DATA_W-1:0]      req_target_value,
   input  logic signed [pdm_pkg::DATA_W-1:0]      req_measured_value,
   input  logic signed [pdm_pkg::DATA_W-1:0]      req_forward_speed,
   output logic signed [pdm_pkg::DATA_W-1:0]      rsp_control_out,
   output logic signed [pdm_pkg::DATA_W-1:0]      rsp_left_speed,
   output logic signed [pdm_pkg::DATA_W-1:0]      rsp_right_speed
);

   localparam int DW = pdm_pkg::DATA_W;
   localparam int SW = pdm_pkg::SUM_W;
   localparam int MW = pdm_pkg::MUL_W;
   localparam int PW = pdm_pkg::PROD_W;

   logic signed [DW-1:0]            gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic        [pdm_pkg::WB_W-1:0] wheel_base_ff;

   logic signed [DW-1:0] target_ff, measured_ff, speed_ff;
   logic signed [DW-1:0] err_ff, last_error_ff;
   logic signed [SW-1:0] error_sum_ff;
   logic signed [MW-1:0] de_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [MW-1:0] ilo_ff;
   logic signed [DW-1:0] term_p_ff, term_i_ff, ctrl_ff;
   logic signed [DW-1:0] out_ctrl_ff, out_left_ff, out_right_ff;

   logic signed [MW-1:0] diff, de_in;
   logic signed [DW-1:0] err_in, term_d, ctrl_in, left_in, right_in;
   logic signed [SW:0]   sum_wide;
   logic signed [SW-1:0] sum_in;
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_in, prod_sh16, integ_full;
   logic signed [DW+1:0] ctrl_wide;
   logic signed [PW-1:0] speed_base, left_full, right_full, left_sh, right_sh;

   assign diff     = {target_ff[DW-1], target_ff} - {measured_ff[DW-1], measured_ff};
   assign err_in   = pdm_pkg::sat32({{(PW-MW){diff[MW-1]}}, diff});
   assign sum_wide = {error_sum_ff[SW-1], error_sum_ff} + {{(SW+1-DW){err_in[DW-1]}}, err_in};
   assign sum_in   = pdm_pkg::sat48(sum_wide);
   assign de_in    = {err_in[DW-1], err_in} - {last_error_ff[DW-1], last_error_ff};

   always_comb begin
      mul_a = {gain_prop_ff[DW-1], gain_prop_ff};
      mul_b = {err_ff[DW-1], err_ff};
      case (cmd.step)
         pdm_pkg::STEP_MUL_IL: begin
            mul_a = {gain_integ_ff[DW-1], gain_integ_ff};
            mul_b = {{(MW-16){1'b0}}, error_sum_ff[15:0]};
         end
         pdm_pkg::STEP_MUL_IH: begin
            mul_a = {gain_integ_ff[DW-1], gain_integ_ff};
            mul_b = {error_sum_ff[SW-1], error_sum_ff[SW-1:16]};
         end
         pdm_pkg::STEP_MUL_D: begin
            mul_a = {gain_deriv_ff[DW-1], gain_deriv_ff};
            mul_b = de_ff;
         end
         pdm_pkg::STEP_MUL_W: begin
            mul_a = {ctrl_ff[DW-1], ctrl_ff};
            mul_b = {{(MW-pdm_pkg::WB_W){1'b0}}, wheel_base_ff};
         end
         default: begin
         end
      endcase
   end

   assign prod_in    = mul_a * mul_b;
   assign prod_sh16  = prod_ff >>> 16;
   assign integ_full = prod_ff + {{(PW-MW){ilo_ff[MW-1]}}, ilo_ff};
   assign term_d     = pdm_pkg::sat32(prod_sh16);
   assign ctrl_wide  = {{2{term_p_ff[DW-1]}}, term_p_ff} + {{2{term_i_ff[DW-1]}}, term_i_ff}
                     + {{2{term_d[DW-1]}}, term_d};
   assign ctrl_in    = pdm_pkg::sat32({{(PW-DW-2){ctrl_wide[DW+1]}}, ctrl_wide});

   assign speed_base = {{(PW-DW-17){speed_ff[DW-1]}}, speed_ff, 17'd0};
   assign left_full  = speed_base - prod_ff;
   assign right_full = speed_base + prod_ff;
   assign left_sh    = left_full >>> 17;
   assign right_sh   = right_full >>> 17;
   assign left_in    = pdm_pkg::sat32(left_sh);
   assign right_in   = pdm_pkg::sat32(right_sh);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff  <= '0;
         gain_integ_ff <= '0;
         gain_deriv_ff <= '0;
         wheel_base_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            pdm_pkg::CSR_GAIN_PROP:  gain_prop_ff  <= csr_wdata;
            pdm_pkg::CSR_GAIN_INTEG: gain_integ_ff <= csr_wdata;
            pdm_pkg::CSR_GAIN_DERIV: gain_deriv_ff <= csr_wdata;
            pdm_pkg::CSR_WHEEL_BASE: wheel_base_ff <= csr_wdata[pdm_pkg::WB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else if (cmd.step == pdm_pkg::STEP_ERR) begin
         error_sum_ff  <= sum_in;
         last_error_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         target_ff   <= req_target_value;
         measured_ff <= req_measured_value;
         speed_ff    <= req_forward_speed;
      end
      case (cmd.step)
         pdm_pkg::STEP_ERR: begin
            err_ff <= err_in;
            de_ff  <= de_in;
         end
         pdm_pkg::STEP_MUL_P: begin
            prod_ff <= prod_in;
         end
         pdm_pkg::STEP_MUL_IL: begin
            prod_ff   <= prod_in;
            term_p_ff <= pdm_pkg::sat32(prod_sh16);
         end
         pdm_pkg::STEP_MUL_IH: begin
            prod_ff <= prod_in;
            ilo_ff  <= prod_sh16[MW-1:0];
         end
         pdm_pkg::STEP_MUL_D: begin
            prod_ff   <= prod_in;
            term_i_ff <= pdm_pkg::sat32(integ_full);
         end
         pdm_pkg::STEP_SUM: begin
            ctrl_ff <= ctrl_in;
         end
         pdm_pkg::STEP_MUL_W: begin
            prod_ff <= prod_in;
         end
         pdm_pkg::STEP_WHEEL: begin
            out_ctrl_ff  <= ctrl_ff;
            out_left_ff  <= left_in;
            out_right_ff <= right_in;
         end
         default: begin
         end
      endcase
   end

   assign rsp_control_out = out_ctrl_ff;
   assign rsp_left_speed  = out_left_ff;
   assign rsp_right_speed = out_right_ff;

endmodule

// File: rtl/pid_differential_drive_mixer.sv
// PID controller with differential-drive wheel mixing, signed Q16.16.
// Request channel (req_valid / req_stall): target, measured value and
// forward speed. A transfer happens at a clock edge with valid high and
// stall low. req_stall is high while an item is in progress.
// Response channel (rsp_valid / rsp_stall): control output and the left
// and right wheel speeds, held in an output register until transferred.
// Register port (csr_valid / csr_ready, csr_index, csr_wdata): 0 proportional
// gain, 1 integral gain, 2 derivative gain, 3 wheel base. csr_ready is always
// high; write only while no item is in progress.
// Each item runs the sequence error, P, I-low, I-high and D products, sum,
// wheel product and final load, on the single shared 33x33 multiplier, used
// five times per item; no new request is taken until the item is through.
// A stalled response holds in the output register while the next request
// is taken and computed; the final load waits until the register is free.
// Reset clears the gains, the wheel base, the error integral, the previous
// error, the controller state and the response valid flag.
`timescale 1ns / 1ps

module pid_differential_drive_mixer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pdm_pkg::DATA_W-1:0]      req_target_value,
   input  logic signed [pdm_pkg::DATA_W-1:0]      req_measured_value,
   input  logic signed [pdm_pkg::DATA_W-1:0]      req_forward_speed,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pdm_pkg::DATA_W-1:0]      rsp_control_out,
   output logic signed [pdm_pkg::DATA_W-1:0]      rsp_left_speed,
   output logic signed [pdm_pkg::DATA_W-1:0]      rsp_right_speed,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [pdm_pkg::CSR_A_W-1:0]     csr_index,
   input  logic        [pdm_pkg::DATA_W-1:0]      csr_wdata
);

   pdm_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   pdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   pdm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_target_value   (req_target_value),
      .req_measured_value (req_measured_value),
      .req_forward_speed  (req_forward_speed),
      .rsp_control_out    (rsp_control_out),
      .rsp_left_speed     (rsp_left_speed),
      .rsp_right_speed    (rsp_right_speed)
   );

endmodule
